// ===== rtl/core/npc_pkg.sv =====
package npc_pkg;

  localparam int PALETTE_DEPTH = 64;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int COLOR_W       = 24;
  localparam int CH_W          = 8;
  localparam int SQ_W          = 2 * CH_W;
  localparam int DIST_W        = 18;
  localparam int PIPE_LAT      = 2 * PALETTE_DEPTH;

  localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // One item as it moves along the row, with the best match found so far
  typedef struct packed {
    logic               vld;
    logic               op;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] color;
    logic               found;
    logic [IDX_W-1:0]   best_index;
    logic [DIST_W-1:0]  best_dist;
  } tok_t;

  function automatic logic [SQ_W-1:0] chan_sq(input logic [CH_W-1:0] x,
                                              input logic [CH_W-1:0] y);
    logic [CH_W-1:0] d;
    d = (x > y) ? (x - y) : (y - x);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

// ===== rtl/core/npc_cell.sv =====
module npc_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [npc_pkg::IDX_W-1:0] cell_idx,
  input  logic [npc_pkg::CNT_W-1:0] palette_count,
  input  npc_pkg::tok_t             tok_in,
  output npc_pkg::tok_t             tok_out
);
  import npc_pkg::*;

  logic [COLOR_W-1:0] entry_r;
  tok_t               tok_a_r;
  logic [SQ_W-1:0]    sq_r [3];
  tok_t               tok_b_r;
  tok_t               tok_b_nxt;
  logic [DIST_W-1:0]  sum_dist;
  logic               active;
  logic               wr_en;

  // The load writes as it passes, so earlier queries have already read this slot
  assign wr_en = tok_in.vld && (tok_in.op == OP_LOAD) && (tok_in.entry_index == cell_idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r <= tok_in.color;
    end
  end

  // Stage A: per-channel squared differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r.vld <= 1'b0;
    end else begin
      tok_a_r.vld <= tok_in.vld;
    end
    tok_a_r.op          <= tok_in.op;
    tok_a_r.entry_index <= tok_in.entry_index;
    tok_a_r.color       <= tok_in.color;
    tok_a_r.found       <= tok_in.found;
    tok_a_r.best_index  <= tok_in.best_index;
    tok_a_r.best_dist   <= tok_in.best_dist;
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= chan_sq(tok_in.color[c*CH_W +: CH_W], entry_r[c*CH_W +: CH_W]);
    end
  end

  // Stage B: sum and compare, strict less-than keeps the lowest index on ties
  assign sum_dist = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  assign active   = {1'b0, cell_idx} < palette_count;

  always_comb begin
    tok_b_nxt = tok_a_r;
    if (tok_a_r.vld && (tok_a_r.op == OP_QUERY) && active &&
        (!tok_a_r.found || (sum_dist < tok_a_r.best_dist))) begin
      tok_b_nxt.found      = 1'b1;
      tok_b_nxt.best_index = cell_idx;
      tok_b_nxt.best_dist  = sum_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_b_r.vld <= 1'b0;
    end else begin
      tok_b_r.vld <= tok_b_nxt.vld;
    end
    tok_b_r.op          <= tok_b_nxt.op;
    tok_b_r.entry_index <= tok_b_nxt.entry_index;
    tok_b_r.color       <= tok_b_nxt.color;
    tok_b_r.found       <= tok_b_nxt.found;
    tok_b_r.best_index  <= tok_b_nxt.best_index;
    tok_b_r.best_dist   <= tok_b_nxt.best_dist;
  end

  assign tok_out = tok_b_r;

endmodule

// ===== rtl/core/nearest_palette_color_unit.sv =====
// Nearest palette colour by squared RGB distance. Every item, query or load,
// walks a row of 64 cells, one per palette slot, two register stages per cell,
// so a query result appears on out_strobe once it has left the last cell, and a
// new item is taken on every cycle: busy stays low. The receiver cannot stall;
// a result is valid for the single cycle out_strobe is high. Loads travel the
// same row and write their slot as they pass, so items keep their issue order.
// Only slots below cfg_palette_count are searched; found = 0 with zero index
// and distance means the palette is empty. Write cfg_palette_count only when
// no item is in flight, and load every slot in use before querying it.
module nearest_palette_color_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_op,
  input  logic [npc_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [npc_pkg::COLOR_W-1:0] in_color,
  input  logic                        cfg_we,
  input  logic [npc_pkg::CNT_W-1:0]   cfg_palette_count,
  output logic                        out_strobe,
  output logic                        out_found,
  output logic [npc_pkg::IDX_W-1:0]   out_nearest_index,
  output logic [npc_pkg::DIST_W-1:0]  out_min_distance
);
  import npc_pkg::*;

  logic [CNT_W-1:0] count_r;
  tok_t             chain [PALETTE_DEPTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_palette_count;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    chain[0].vld         = start;
    chain[0].op          = in_op;
    chain[0].entry_index = in_entry_index;
    chain[0].color       = in_color;
    chain[0].found       = 1'b0;
    chain[0].best_index  = '0;
    chain[0].best_dist   = '0;
  end

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npc_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cell_idx      (IDX_W'(k)),
      .palette_count (count_r),
      .tok_in        (chain[k]),
      .tok_out       (chain[k+1])
    );
  end

  assign out_strobe        = chain[PALETTE_DEPTH].vld && (chain[PALETTE_DEPTH].op == OP_QUERY);
  assign out_found         = chain[PALETTE_DEPTH].found;
  assign out_nearest_index = chain[PALETTE_DEPTH].best_index;
  assign out_min_distance  = chain[PALETTE_DEPTH].best_dist;

`ifndef ASSERT_OFF
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && (in_op == OP_QUERY), PIPE_LAT))
    else $error("result without a matching query");

  a_default_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_nearest_index == '0 && out_min_distance == '0))
    else $error("default result carries nonzero fields");

  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_min_distance <= MAX_DIST))
    else $error("distance out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
  } match_t;

  class nearest_color_board;
    logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
    logic [CNT_W-1:0]   palette_count;
    match_t             pending_matches [$];
    int                 fail_count;
    int                 lookups;
    int                 writes;
    int                 compared;

    function new();
      foreach (palette[i]) palette[i] = '0;
      palette_count = '0;
      fail_count = 0;
      lookups = 0;
      writes = 0;
      compared = 0;
    endfunction

    function int squared_gap(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b);
      int sum;
      int diff;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        diff = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
        sum += diff * diff;
      end
      return sum;
    endfunction

    function match_t find_nearest(logic [COLOR_W-1:0] colour);
      match_t best;
      int     span;
      int     d;
      best = '0;
      span = (palette_count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(palette_count);
      // strict less-than keeps the lowest index on a tie
      for (int i = 0; i < span; i++) begin
        d = squared_gap(colour, palette[i]);
        if (!best.found || d < int'(best.distance)) begin
          best.found    = 1'b1;
          best.index    = IDX_W'(i);
          best.distance = DIST_W'(d);
        end
      end
      return best;
    endfunction

    function void note_item(logic op, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] colour);
      if (op == OP_LOAD) begin
        palette[idx] = colour;
        writes++;
      end else begin
        pending_matches.push_back(find_nearest(colour));
        lookups++;
      end
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 20) $display("MISMATCH: %s", msg);
    endtask

    task check_result(logic f, logic [IDX_W-1:0] idx, logic [DIST_W-1:0] d);
      match_t want;
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("result with no query waiting (index %0d, distance %0d)",
                                  idx, d));
      end else begin
        want = pending_matches.pop_front();
        compared++;
        if (f !== want.found)
          report_mismatch($sformatf("result %0d found got %0b want %0b",
                                    compared, f, want.found));
        if (idx !== want.index)
          report_mismatch($sformatf("result %0d nearest_index got %0d want %0d",
                                    compared, idx, want.index));
        if (d !== want.distance)
          report_mismatch($sformatf("result %0d min_distance got %0d want %0d",
                                    compared, d, want.distance));
      end
    endtask

    task drain_check();
      while (pending_matches.size() != 0) begin
        void'(pending_matches.pop_front());
        report_mismatch("query result never arrived");
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_op = OP_QUERY;
  logic [IDX_W-1:0]   in_entry_index = '0;
  logic [COLOR_W-1:0] in_color = '0;
  logic               cfg_we = 1'b0;
  logic [CNT_W-1:0]   cfg_palette_count = '0;
  logic               out_strobe;
  logic               out_found;
  logic [IDX_W-1:0]   out_nearest_index;
  logic [DIST_W-1:0]  out_min_distance;

  nearest_color_board board = new();
  int                 sizes_tried = 0;

  nearest_palette_color_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_entry_index    (in_entry_index),
    .in_color          (in_color),
    .cfg_we            (cfg_we),
    .cfg_palette_count (cfg_palette_count),
    .out_strobe        (out_strobe),
    .out_found         (out_found),
    .out_nearest_index (out_nearest_index),
    .out_min_distance  (out_min_distance)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      board.check_result(out_found, out_nearest_index, out_min_distance);
    end
  end

  // Leave start high on return so back-to-back items need no second assignment.
  task send_item(logic op, logic [IDX_W-1:0] idx, logic [COLOR_W-1:0] colour, int idle_pct);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_entry_index <= idx;
    in_color       <= colour;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(op, idx, colour);
  endtask

  task set_palette_count(logic [CNT_W-1:0] value);
    start <= 1'b0;
    while (board.pending_matches.size() != 0) @(posedge clk);
    // let trailing loads clear the row before the count changes
    repeat (PIPE_LAT + 8) @(posedge clk);
    cfg_we            <= 1'b1;
    cfg_palette_count <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.palette_count = value;
    sizes_tried++;
  endtask

  function logic [COLOR_W-1:0] corner_colour();
    return {($urandom_range(0, 1) ? 8'hFF : 8'h00),
            ($urandom_range(0, 1) ? 8'hFF : 8'h00),
            ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
  endfunction

  function logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] colour);
    logic [COLOR_W-1:0] moved;
    int                 v;
    for (int k = 0; k < 3; k++) begin
      v = int'(colour[8*k +: 8]) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      moved[8*k +: 8] = 8'(v);
    end
    return moved;
  endfunction

  task run_mix(int n_items, int idle_pct);
    int                 span;
    int                 pick;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] colour;
    for (int n = 0; n < n_items; n++) begin
      span = (board.palette_count > PALETTE_DEPTH) ? PALETTE_DEPTH
                                                   : int'(board.palette_count);
      idx  = IDX_W'($urandom());
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 3) begin
        // copies of existing entries give ties to resolve
        if (pick < 6) colour = COLOR_W'($urandom());
        else if (pick < 9) colour = board.palette[$urandom_range(0, PALETTE_DEPTH - 1)];
        else colour = corner_colour();
        send_item(OP_LOAD, idx, colour, idle_pct);
      end else begin
        if (pick < 4 || span == 0) colour = COLOR_W'($urandom());
        else if (pick < 8) colour = nudge(board.palette[$urandom_range(0, span - 1)]);
        else if (pick < 9) colour = board.palette[$urandom_range(0, span - 1)];
        else colour = corner_colour();
        if (span == 0 && pick >= 8) colour = corner_colour();
        send_item(OP_QUERY, idx, colour, idle_pct);
      end
    end
  endtask

  initial begin
    int sizes [10];
    int idle_plan [3];
    int waited;
    sizes     = '{64, 127, 1, 65, -1, 0, 100, 64, -1, 2};
    idle_plan = '{0, 71, 19};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty palette
    send_item(OP_QUERY, 6'd0, 24'h000000, 0);
    send_item(OP_QUERY, 6'd63, 24'hFFFFFF, 0);
    send_item(OP_LOAD, 6'd0, 24'h000000, 0);
    send_item(OP_LOAD, 6'd1, 24'hFFFFFF, 0);
    send_item(OP_LOAD, 6'd2, 24'h808080, 0);
    send_item(OP_LOAD, 6'd3, 24'h808080, 0);
    send_item(OP_LOAD, 6'd63, 24'h00FF00, 0);

    // single entry: largest possible distance
    set_palette_count(7'd1);
    send_item(OP_QUERY, 6'd0, 24'hFFFFFF, 0);
    send_item(OP_QUERY, 6'd21, 24'h000000, 0);

    // equal entries at 2 and 3: the lower index must win
    set_palette_count(7'd4);
    send_item(OP_QUERY, 6'd42, 24'h808080, 0);
    send_item(OP_QUERY, 6'd0, 24'h7F7F7F, 0);
    send_item(OP_QUERY, 6'd0, 24'h818181, 0);
    send_item(OP_QUERY, 6'd0, 24'hFF00FF, 0);
    send_item(OP_QUERY, 6'd0, 24'h00FF00, 0);
    send_item(OP_QUERY, 6'd0, 24'h123456, 0);

    // fill every slot before any wider search
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_item(OP_LOAD, IDX_W'(i), COLOR_W'($urandom()), 19);

    for (int p = 0; p < 10; p++) begin
      set_palette_count(CNT_W'((sizes[p] < 0) ? $urandom_range(2, 63) : sizes[p]));
      run_mix(165, idle_plan[p % 3]);
    end

    start <= 1'b0;
    waited = 0;
    while (board.pending_matches.size() != 0 && waited < 4 * PIPE_LAT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 16) @(posedge clk);
    board.drain_check();

    $display("Covered %0d lookups and %0d palette writes over %0d palette sizes,",
             board.lookups, board.writes, sizes_tried + 1);
    $display("%0d results compared, %0d mismatches", board.compared, board.fail_count);
    if (board.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("Run timed out");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== nearest_palette_color_unit.f =====
rtl/core/npc_pkg.sv
rtl/core/npc_cell.sv
rtl/core/nearest_palette_color_unit.sv
tb/testbench.sv
